[hdl/gtca_pkg.sv]
// Package with the transaction types and register codes of the global timer.
package gtca_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CountWidth = 64;
    localparam int unsigned PrescaleWidth = 8;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ADDR_COUNT_LO = 3'd0,
        ADDR_COUNT_HI = 3'd1,
        ADDR_CONTROL  = 3'd2,
        ADDR_STATUS   = 3'd3,
        ADDR_CMP_LO   = 3'd4,
        ADDR_CMP_HI   = 3'd5,
        ADDR_STEP     = 3'd6,
        ADDR_UNUSED   = 3'd7
    } addr_t;

    // Bit positions in the control register as seen on the bus.
    localparam int unsigned CtrlTimerEnBit = 0;
    localparam int unsigned CtrlCmpEnBit = 1;
    localparam int unsigned CtrlIrqEnBit = 2;
    localparam int unsigned CtrlAutoIncBit = 3;
    localparam int unsigned CtrlPrescaleLsb = 8;
    localparam int unsigned StatusClearBit = 0;

    typedef struct packed {
        logic [PrescaleWidth-1:0] prescale;
        logic                     auto_inc;
        logic                     irq_en;
        logic                     cmp_en;
        logic                     timer_en;
    } ctrl_t;

    typedef struct packed {
        mode_t                mode;
        addr_t                address;
        logic [DataWidth-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DataWidth-1:0] read_data;
        logic                 irq;
    } out_item_t;

endpackage

[hdl/global_timer_comparator_autoincrement.sv]
// Global 64-bit timer with comparator and auto-increment, driven by bus and tick transactions.
// The input register holds each transaction and the result register holds its result.
// Throughput, while out_ready is high: one transaction per cycle; the input and result registers
// both hand on in the same cycle, so a stalled result never blocks a free input slot.
// Reset: rst_n clears the counter, prescale phase, control, event flag, comparator
// and increment registers to zero, and empties both pipeline registers.
module global_timer_comparator_autoincrement (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtca_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gtca_pkg::out_item_t out_data
);

    localparam int unsigned DW = gtca_pkg::DataWidth;
    localparam int unsigned CW = gtca_pkg::CountWidth;
    localparam int unsigned PW = gtca_pkg::PrescaleWidth;

    // Input register: holds one accepted transaction until it is processed.
    logic               in_valid_reg;
    gtca_pkg::in_item_t in_item_reg;

    // Result register.
    logic                out_valid_reg;
    gtca_pkg::out_item_t out_data_reg;
    gtca_pkg::out_item_t out_data_next;

    // Architectural timer state.
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   phase_reg, phase_next;
    gtca_pkg::ctrl_t ctrl_reg, ctrl_next;
    logic            event_reg, event_next;
    logic [CW-1:0]   cmp_reg, cmp_next;
    logic [DW-1:0]   step_reg, step_next;

    // The held transaction is processed when the result register is free or
    // is being emptied in this cycle. State is updated at that same edge, so
    // the next transaction always sees the effect of the previous one.
    logic advance;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Tick datapath: one increment followed by the compare, with the
    // auto-increment sum formed in parallel and selected afterwards.
    logic [CW-1:0] count_inc;
    logic          cmp_hit;
    logic [CW-1:0] cmp_sum;
    logic          phase_done;

    assign count_inc  = count_reg + {{(CW-1){1'b0}}, 1'b1};
    assign cmp_hit    = count_inc >= cmp_reg;
    assign cmp_sum    = cmp_reg + {{(CW-DW){1'b0}}, step_reg};
    assign phase_done = phase_reg >= ctrl_reg.prescale;

    // Bus view of the control register.
    logic [DW-1:0] ctrl_read;
    always_comb
    begin
        ctrl_read = '0;
        ctrl_read[gtca_pkg::CtrlTimerEnBit] = ctrl_reg.timer_en;
        ctrl_read[gtca_pkg::CtrlCmpEnBit]   = ctrl_reg.cmp_en;
        ctrl_read[gtca_pkg::CtrlIrqEnBit]   = ctrl_reg.irq_en;
        ctrl_read[gtca_pkg::CtrlAutoIncBit] = ctrl_reg.auto_inc;
        ctrl_read[gtca_pkg::CtrlPrescaleLsb +: PW] = ctrl_reg.prescale;
    end

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        ctrl_next  = ctrl_reg;
        event_next = event_reg;
        cmp_next   = cmp_reg;
        step_next  = step_reg;
        out_data_next.read_data = '0;

        case (in_item_reg.mode)
            gtca_pkg::MODE_TICK:
            begin
                // A disabled timer ignores ticks entirely.
                if (ctrl_reg.timer_en)
                begin
                    if (phase_done)
                    begin
                        phase_next = '0;
                        count_next = count_inc;
                        if (ctrl_reg.cmp_en && cmp_hit)
                        begin
                            event_next = 1'b1;
                            if (ctrl_reg.auto_inc)
                            begin
                                cmp_next = cmp_sum;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + {{(PW-1){1'b0}}, 1'b1};
                    end
                end
            end
            gtca_pkg::MODE_READ:
            begin
                case (in_item_reg.address)
                    gtca_pkg::ADDR_COUNT_LO: out_data_next.read_data = count_reg[DW-1:0];
                    gtca_pkg::ADDR_COUNT_HI: out_data_next.read_data = count_reg[CW-1:DW];
                    gtca_pkg::ADDR_CONTROL:  out_data_next.read_data = ctrl_read;
                    gtca_pkg::ADDR_STATUS:   out_data_next.read_data = {{(DW-1){1'b0}}, event_reg};
                    gtca_pkg::ADDR_CMP_LO:   out_data_next.read_data = cmp_reg[DW-1:0];
                    gtca_pkg::ADDR_CMP_HI:   out_data_next.read_data = cmp_reg[CW-1:DW];
                    gtca_pkg::ADDR_STEP:     out_data_next.read_data = step_reg;
                    default:                 out_data_next.read_data = '0;
                endcase
            end
            gtca_pkg::MODE_WRITE:
            begin
                case (in_item_reg.address)
                    gtca_pkg::ADDR_COUNT_LO:
                    begin
                        // Counter writes are dropped while the timer runs.
                        if (!ctrl_reg.timer_en)
                        begin
                            count_next[DW-1:0] = in_item_reg.write_data;
                        end
                    end
                    gtca_pkg::ADDR_COUNT_HI:
                    begin
                        if (!ctrl_reg.timer_en)
                        begin
                            count_next[CW-1:DW] = in_item_reg.write_data;
                        end
                    end
                    gtca_pkg::ADDR_CONTROL:
                    begin
                        ctrl_next.timer_en = in_item_reg.write_data[gtca_pkg::CtrlTimerEnBit];
                        ctrl_next.cmp_en   = in_item_reg.write_data[gtca_pkg::CtrlCmpEnBit];
                        ctrl_next.irq_en   = in_item_reg.write_data[gtca_pkg::CtrlIrqEnBit];
                        ctrl_next.auto_inc = in_item_reg.write_data[gtca_pkg::CtrlAutoIncBit];
                        ctrl_next.prescale =
                            in_item_reg.write_data[gtca_pkg::CtrlPrescaleLsb +: PW];
                    end
                    gtca_pkg::ADDR_STATUS:
                    begin
                        // Write one to clear the event flag.
                        if (in_item_reg.write_data[gtca_pkg::StatusClearBit])
                        begin
                            event_next = 1'b0;
                        end
                    end
                    gtca_pkg::ADDR_CMP_LO: cmp_next[DW-1:0]  = in_item_reg.write_data;
                    gtca_pkg::ADDR_CMP_HI: cmp_next[CW-1:DW] = in_item_reg.write_data;
                    gtca_pkg::ADDR_STEP:   step_next         = in_item_reg.write_data;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // The interrupt line reflects the state after this transaction.
        out_data_next.irq = event_next && ctrl_next.irq_en;
    end

    // Control and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= '0;
            ctrl_reg      <= '0;
            event_reg     <= 1'b0;
            cmp_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                phase_reg     <= phase_next;
                ctrl_reg      <= ctrl_next;
                event_reg     <= event_next;
                cmp_reg       <= cmp_next;
                step_reg      <= step_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // A stopped timer keeps its count unless software writes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl_reg.timer_en && !(advance && in_item_reg.mode == gtca_pkg::MODE_WRITE))
        |=> $stable(count_reg))
    else $error("counter moved while the timer was stopped");

    // The event flag can only be raised by a processed tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(event_reg) |-> $past(advance && in_item_reg.mode == gtca_pkg::MODE_TICK))
    else $error("event flag set by a non-tick transaction");

    // The stored interrupt bit matches the state left by the same transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data_reg.irq == (event_reg && ctrl_reg.irq_en)))
    else $error("irq in result disagrees with timer state");

    // Only reads return data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.mode != gtca_pkg::MODE_READ)
        |=> (out_data_reg.read_data == '0))
    else $error("non-read transaction returned data");

    // A running counter only moves on a prescaler rollover.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctrl_reg.timer_en) && (count_reg != $past(count_reg))) |-> (phase_reg == '0))
    else $error("counter advanced without a prescaler rollover");
`endif

endmodule
